// ----- design/first_fit_heap_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Assertion forms for the allocator control module, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFHA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Sizes, codes and the types shared by the control unit and the table cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
	localparam int HEADER_BYTES = 16;
	localparam int ADDR_W       = 32;
	localparam int SIZE_W       = 24;
	localparam int NEED_W       = SIZE_W + 1;
	localparam int MSPLIT_W     = 13;
	localparam int STATUS_W     = 2;
	localparam int CFG_IDX_W    = 2;

	localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(65536 - HEADER_BYTES);
	localparam logic [ADDR_W-1:0] RESET_HEAP_END = ADDR_W'(65536);
	localparam logic [MSPLIT_W-1:0] RESET_MIN_SPLIT = MSPLIT_W'(16);

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BADFREE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPLIT  = 2'd2;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_RELOAD,
		CMD_TAKE,
		CMD_SPLIT,
		CMD_RELEASE,
		CMD_MERGE
	} cmd_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_DECIDE,
		S_MERGE_NEXT,
		S_MERGE_PREV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              valid;
		logic              used;
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
	} entry_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  idx;
		logic [ADDR_W-1:0] addr;
		logic              split_ok;
		logic              used;
		logic              prev_free;
		logic              next_free;
	} sweep_t;

	typedef struct packed {
		logic                is_free;
		logic [NEED_W-1:0]   need;
		logic [ADDR_W-1:0]   addr;
		logic [MSPLIT_W-1:0] min_split;
	} req_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [IDX_W-1:0]  idx;
		logic [NEED_W-1:0] need;
		logic [ADDR_W-1:0] start;
		logic [SIZE_W-1:0] size;
	} cmd_t;

	localparam entry_t EMPTY_ENTRY = '0;

endpackage

`default_nettype wire

// ----- design/ffha_cell.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator table cell
// Holds one block entry, checks it against the request as the sweep passes,
// and shifts with its neighbors on insert and merge commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffha_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          init_valid,
	input  logic [ffha_pkg::IDX_W-1:0]    pos,
	input  ffha_pkg::req_t                req,
	input  ffha_pkg::cmd_t                cmd,
	input  ffha_pkg::entry_t              left,
	input  ffha_pkg::entry_t              right,
	input  ffha_pkg::sweep_t              sweep_in,
	output ffha_pkg::entry_t              entry,
	output ffha_pkg::sweep_t              sweep_out
);
	import ffha_pkg::*;

	entry_t            entry_q;
	entry_t            entry_d;
	sweep_t            sweep_q;
	sweep_t            sweep_d;
	logic [ADDR_W-1:0] payload;
	logic              fit;
	logic              hit;
	logic              split_ok;
	logic [NEED_W:0]   split_min;
	logic [NEED_W:0]   merged;
	logic [IDX_W:0]    pos_x;
	logic [IDX_W:0]    idx_x;
	logic [IDX_W:0]    idx_next;

	always_comb begin
		payload   = entry_q.start + ADDR_W'(HEADER_BYTES);
		fit       = entry_q.valid && !entry_q.used && ({1'b0, entry_q.size} >= req.need);
		hit       = req.is_free ? (entry_q.valid && (payload == req.addr)) : fit;
		split_min = {1'b0, req.need} + (NEED_W+1)'(HEADER_BYTES)
			+ (NEED_W+1)'(req.min_split);
		split_ok  = {2'b00, entry_q.size} >= split_min;

		sweep_d = sweep_in;
		if (!sweep_in.found && hit) begin
			sweep_d = '{found: 1'b1, idx: pos, addr: payload, split_ok: split_ok,
				used: entry_q.used, prev_free: left.valid && !left.used,
				next_free: right.valid && !right.used};
		end

		merged   = {2'b00, entry_q.size} + {2'b00, right.size} + (NEED_W+1)'(HEADER_BYTES);
		pos_x    = {1'b0, pos};
		idx_x    = {1'b0, cmd.idx};
		idx_next = idx_x + 1'b1;

		entry_d = entry_q;
		case (cmd.op)
			CMD_NONE: begin
			end
			CMD_RELOAD: begin
				if (pos == '0) begin
					entry_d = '{valid: 1'b1, used: 1'b0, start: cmd.start, size: cmd.size};
				end else begin
					entry_d.valid = 1'b0;
					entry_d.used  = 1'b0;
				end
			end
			CMD_TAKE: begin
				if (pos_x == idx_x) entry_d.used = 1'b1;
			end
			CMD_SPLIT: begin
				if (pos_x == idx_x) begin
					entry_d.size = cmd.need[SIZE_W-1:0];
					entry_d.used = 1'b1;
				end else if (pos_x == idx_next) begin
					entry_d = '{valid: 1'b1, used: 1'b0,
						start: left.start + ADDR_W'(HEADER_BYTES) + ADDR_W'(cmd.need),
						size: left.size - cmd.need[SIZE_W-1:0] - SIZE_W'(HEADER_BYTES)};
				end else if (pos_x > idx_next) begin
					entry_d = left;
				end
			end
			CMD_RELEASE: begin
				if (pos_x == idx_x) entry_d.used = 1'b0;
			end
			CMD_MERGE: begin
				if (pos_x == idx_x) begin
					entry_d.size = (merged[NEED_W:SIZE_W] != '0) ? '1 : merged[SIZE_W-1:0];
				end else if (pos_x > idx_x) begin
					entry_d = right;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '{valid: init_valid, used: 1'b0, start: '0, size: RESET_SIZE};
			sweep_q <= '0;
		end else begin
			entry_q <= entry_d;
			sweep_q <= sweep_d;
		end
	end

	assign entry     = entry_q;
	assign sweep_out = sweep_q;

endmodule

`default_nettype wire

// ----- design/ffha_ctrl.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator control
// Holds configuration and block count, sequences sweep, update commands and
// the registered result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"

module ffha_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [23:0]                     alloc_size,
	input  logic [31:0]                     free_address,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [31:0]                     address,
	output logic [1:0]                      status,
	input  logic                            cfg_we,
	input  logic [ffha_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                     cfg_wdata,
	input  ffha_pkg::sweep_t                result,
	output ffha_pkg::req_t                  req,
	output ffha_pkg::cmd_t                  cmd
);
	import ffha_pkg::*;

	state_t              state_q, state_d;
	logic [IDX_W-1:0]    cnt_q, cnt_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic                prev_free_q, prev_free_d;
	logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic                is_free_q;
	logic [NEED_W-1:0]   need_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [ADDR_W-1:0]   heap_start_q;
	logic [ADDR_W-1:0]   heap_end_q;
	logic [MSPLIT_W-1:0] min_split_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   address_q;
	logic [STATUS_W-1:0] status_q;
	logic                capture;
	logic                load_out;
	logic                reload;
	logic [ADDR_W-1:0]   new_start;
	logic [ADDR_W-1:0]   new_end;
	logic [ADDR_W+1:0]   total;
	logic [SIZE_W-1:0]   init_size;
	logic [NEED_W-1:0]   need_in;

	always_comb begin
		reload    = cfg_we && ((cfg_index == REG_HEAP_START) || (cfg_index == REG_HEAP_END));
		new_start = (cfg_index == REG_HEAP_START) ? cfg_wdata : heap_start_q;
		new_end   = (cfg_index == REG_HEAP_END) ? cfg_wdata : heap_end_q;
		total     = {2'b00, new_end} - {2'b00, new_start} - (ADDR_W+2)'(HEADER_BYTES);
		if (total[ADDR_W+1]) init_size = '0;
		else if (total[ADDR_W:SIZE_W] != '0) init_size = '1;
		else init_size = total[SIZE_W-1:0];
		need_in   = ({1'b0, alloc_size} + NEED_W'(3)) & ~NEED_W'(3);
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		count_d      = count_q;
		idx_d        = idx_q;
		prev_free_d  = prev_free_q;
		res_addr_d   = res_addr_q;
		res_status_d = res_status_q;
		in_ready     = 1'b0;
		capture      = 1'b0;
		load_out     = 1'b0;
		cmd = '{op: CMD_NONE, idx: idx_q, need: need_q, start: new_start, size: init_size};
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					capture = 1'b1;
					cnt_d   = '0;
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == IDX_W'(MAX_BLOCKS - 1)) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				idx_d       = result.idx;
				prev_free_d = result.prev_free;
				cmd.idx     = result.idx;
				state_d     = S_DONE;
				res_addr_d  = '0;
				if (!is_free_q) begin
					if (!result.found) begin
						res_status_d = STAT_NOSPACE;
					end else begin
						res_status_d = STAT_OK;
						res_addr_d   = result.addr;
						if (result.split_ok && (count_q < CNT_W'(MAX_BLOCKS))) begin
							cmd.op  = CMD_SPLIT;
							count_d = count_q + 1'b1;
						end else begin
							cmd.op = CMD_TAKE;
						end
					end
				end else if (!result.found || !result.used) begin
					res_status_d = STAT_BADFREE;
				end else begin
					res_status_d = STAT_OK;
					cmd.op       = CMD_RELEASE;
					if (result.next_free) state_d = S_MERGE_NEXT;
					else if (result.prev_free) state_d = S_MERGE_PREV;
				end
			end
			S_MERGE_NEXT: begin
				cmd.op  = CMD_MERGE;
				count_d = count_q - 1'b1;
				state_d = prev_free_q ? S_MERGE_PREV : S_DONE;
			end
			S_MERGE_PREV: begin
				cmd.op  = CMD_MERGE;
				cmd.idx = idx_q - 1'b1;
				count_d = count_q - 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (reload) begin
			cmd.op  = CMD_RELOAD;
			count_d = CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			count_q      <= CNT_W'(1);
			idx_q        <= '0;
			prev_free_q  <= 1'b0;
			res_addr_q   <= '0;
			res_status_q <= STAT_OK;
			is_free_q    <= 1'b0;
			need_q       <= '0;
			addr_q       <= '0;
			heap_start_q <= '0;
			heap_end_q   <= RESET_HEAP_END;
			min_split_q  <= RESET_MIN_SPLIT;
			out_valid_q  <= 1'b0;
			address_q    <= '0;
			status_q     <= STAT_OK;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			count_q      <= count_d;
			idx_q        <= idx_d;
			prev_free_q  <= prev_free_d;
			res_addr_q   <= res_addr_d;
			res_status_q <= res_status_d;
			if (capture) begin
				is_free_q <= req_type;
				need_q    <= need_in;
				addr_q    <= free_address;
			end
			if (cfg_we) begin
				if (cfg_index == REG_HEAP_START) heap_start_q <= cfg_wdata;
				if (cfg_index == REG_HEAP_END) heap_end_q <= cfg_wdata;
				if (cfg_index == REG_MIN_SPLIT) min_split_q <= cfg_wdata[MSPLIT_W-1:0];
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				address_q   <= res_addr_q;
				status_q    <= res_status_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req       = '{is_free: is_free_q, need: need_q, addr: addr_q, min_split: min_split_q};
	assign out_valid = out_valid_q;
	assign address   = address_q;
	assign status    = status_q;

	`FFHA_ASSERT_NEXT(a_split_grows, (state_q == S_DECIDE) && !reload && !is_free_q && result.found && result.split_ok && (count_q < CNT_W'(MAX_BLOCKS)), count_q == CNT_W'($past(count_q) + 1'b1), "split did not grow block count")
	`FFHA_ASSERT_NOW(a_err_zero_addr, out_valid_q && (status_q != STAT_OK), address_q == '0, "error result carries an address")
	`FFHA_ASSERT_NEXT(a_reload_count, reload, count_q == CNT_W'(1), "reload did not reset block count")

endmodule

`default_nettype wire

// ----- design/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Address-ordered block table in a row of cells with first-fit allocate,
// free with neighbor coalescing, and region reload on heap start or end writes.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid/in_ready    req_type, alloc_size, free_address
// out      out_valid/out_ready  address, status
// cfg      cfg_we               cfg_index, cfg_wdata
//
// A transaction sweeps the request through the cell row one cell per cycle,
// then runs the update states (S_DECIDE, plus S_MERGE_NEXT and S_MERGE_PREV
// when a free coalesces) and S_DONE, which loads the output register when free.
// Reset leaves one free block covering the default region; no clearing pass.
// A new request is taken while a finished result waits at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [23:0]                    alloc_size,
	input  logic [31:0]                    free_address,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    address,
	output logic [1:0]                     status,
	input  logic                           cfg_we,
	input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_wdata
);
	import ffha_pkg::*;

	req_t   req;
	cmd_t   cmd;
	entry_t entries [MAX_BLOCKS];
	sweep_t sweeps  [MAX_BLOCKS];

	ffha_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.alloc_size   (alloc_size),
		.free_address (free_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.address      (address),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.result       (sweeps[MAX_BLOCKS-1]),
		.req          (req),
		.cmd          (cmd)
	);

	for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		sweep_t sweep_prev;

		if (k == 0) begin : g_first
			assign left_e     = EMPTY_ENTRY;
			assign sweep_prev = '0;
		end else begin : g_mid
			assign left_e     = entries[k-1];
			assign sweep_prev = sweeps[k-1];
		end

		if (k == MAX_BLOCKS - 1) begin : g_last
			assign right_e = EMPTY_ENTRY;
		end else begin : g_inner
			assign right_e = entries[k+1];
		end

		ffha_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.init_valid (k == 0),
			.pos        (IDX_W'(k)),
			.req        (req),
			.cmd        (cmd),
			.left       (left_e),
			.right      (right_e),
			.sweep_in   (sweep_prev),
			.entry      (entries[k]),
			.sweep_out  (sweeps[k])
		);
	end

endmodule

`default_nettype wire
